// ----- hw/rtl/hwb_pkg.sv -----
// shared types, constants and codes of the homography warp core
`timescale 1ns / 1ps
package hwb_pkg;

   localparam int HWB_NREG      = 8;
   localparam int HWB_COEF_W    = 40;
   localparam int HWB_FRAC_BITS = 24;
   localparam int HWB_UV_W      = 12;
   localparam int HWB_PROD_W    = 52;
   localparam int HWB_NUM_W     = 55;
   localparam int HWB_CF        = 16;
   localparam int HWB_QI_MAX    = 11;
   localparam int HWB_QUOT_W    = HWB_QI_MAX + HWB_CF;
   localparam int HWB_ADDR_W    = 18;
   localparam int HWB_PIX_W     = 24;
   localparam int HWB_CALC_W    = 24;
   localparam int HWB_WGT_W     = 33;
   localparam int HWB_ACC_W     = 40;
   localparam int HWB_BOX_W     = 11;
   localparam int HWB_CSR_AW    = 6;
   localparam int HWB_CSR_DW    = 64;
   localparam int HWB_REQ_DW    = 48;
   localparam int HWB_RSP_DW    = 64;
   localparam int HWB_SRC_W_DEF = 512;
   localparam int HWB_SRC_H_DEF = 512;

   localparam logic signed [HWB_COEF_W-1:0] HWB_COEF_ONE =
      HWB_COEF_W'(1) << HWB_FRAC_BITS;
   localparam logic signed [HWB_NUM_W-1:0] HWB_W_ONE =
      HWB_NUM_W'(1) << HWB_FRAC_BITS;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_CLEAR   = 2'd1,
      CMD_MEASURE = 2'd2,
      CMD_RENDER  = 2'd3
   } hwb_cmd_type;

   typedef enum logic [2:0] {
      CSR_COEF_XX = 3'd0,
      CSR_COEF_XY = 3'd1,
      CSR_COEF_XC = 3'd2,
      CSR_COEF_YX = 3'd3,
      CSR_COEF_YY = 3'd4,
      CSR_COEF_YC = 3'd5,
      CSR_COEF_WX = 3'd6,
      CSR_COEF_WY = 3'd7
   } hwb_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_START,
      ST_DIV,
      ST_CHECK,
      ST_RD,
      ST_ACC,
      ST_DONE
   } hwb_state_type;

   typedef struct packed {
      logic                  done;
      logic                  ok;
      logic [HWB_QUOT_W-1:0] quot;
   } hwb_div_res_type;

endpackage

// ----- hw/rtl/hwb_pix_mem.sv -----
// source image memory, one write port and one registered read port
`timescale 1ns / 1ps
module hwb_pix_mem (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [hwb_pkg::HWB_ADDR_W-1:0] wr_addr,
   input  logic [hwb_pkg::HWB_PIX_W-1:0]  wr_data,
   input  logic                           rd_en,
   input  logic [hwb_pkg::HWB_ADDR_W-1:0] rd_addr,
   output logic [hwb_pkg::HWB_PIX_W-1:0]  rd_data
);
   import hwb_pkg::*;

   logic [HWB_PIX_W-1:0] mem [2**HWB_ADDR_W];
   logic [HWB_PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/hwb_div.sv -----
// iterative restoring divider, one quotient bit per cycle, 16 fraction bits
`timescale 1ns / 1ps
module hwb_div #(
   parameter int QI    = 9,
   parameter int LIMIT = 512
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [hwb_pkg::HWB_NUM_W-1:0]  num,
   input  logic signed [hwb_pkg::HWB_NUM_W-1:0]  den,
   output hwb_pkg::hwb_div_res_type              res
);
   import hwb_pkg::*;

   localparam int NW    = HWB_NUM_W;
   localparam int DW    = NW + QI;
   localparam int QW    = QI + HWB_CF;
   localparam int CNTW  = $clog2(QW);

   logic [NW-1:0]   an;
   logic [NW-1:0]   ad;
   logic            flag_in;
   logic [NW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   dvs_ff, dvs_in;
   logic [NW-1:0]   ad_ff;
   logic [QW-1:0]   q_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff, done_ff, flag_ff;
   logic [DW-1:0]   rem_ext;
   logic [NW:0]     rem_dbl;
   logic            bit_in;
   logic            int_phase;

   assign an = num[NW-1] ? (~num + 1'b1) : num;
   assign ad = den[NW-1] ? (~den + 1'b1) : den;

   // valid unless zero divisor, opposite signs, or integer part beyond the range
   assign flag_in = (den != '0) && !((num != '0) && (num[NW-1] != den[NW-1])) &&
                    ({{QI{1'b0}}, an} < {ad, {QI{1'b0}}});

   assign int_phase = cnt_ff < CNTW'(QI);
   assign rem_ext   = {{QI{1'b0}}, rem_ff};
   assign rem_dbl   = {rem_ff, 1'b0};

   always_comb begin
      dvs_in = dvs_ff;
      if (int_phase) begin
         bit_in = rem_ext >= dvs_ff;
         rem_in = bit_in ? NW'(rem_ext - dvs_ff) : rem_ff;
         if (cnt_ff < CNTW'(QI - 1)) begin
            dvs_in = dvs_ff >> 1;
         end
      end else begin
         bit_in = rem_dbl >= {1'b0, ad_ff};
         rem_in = bit_in ? NW'(rem_dbl - {1'b0, ad_ff}) : NW'(rem_dbl);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= an;
         ad_ff   <= ad;
         dvs_ff  <= DW'(ad) << (QI - 1);
         flag_ff <= flag_in;
         q_ff    <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvs_ff <= dvs_in;
         q_ff   <= {q_ff[QW-2:0], bit_in};
      end
   end

   assign res.done = done_ff;
   assign res.ok   = flag_ff && ({1'b0, q_ff[QW-1:HWB_CF]} < (QI + 1)'(LIMIT));
   assign res.quot = HWB_QUOT_W'(q_ff);

endmodule

// ----- hw/rtl/homography_warp_bilinear_core.sv -----
// top level of the homography warp core with bilinear sampling
`timescale 1ns / 1ps
//
// channel  direction  handshake            payload
// req      in         req_tvalid/tready    tdata pos_x,pos_y,rgb; tuser cmd
// rsp      out        rsp_tvalid/tready    tdata dest_x,dest_y,rgb,tex_index
// csr      in         psel/penable/pwrite  8 coefficients, 40 bit, at 8*i
//
// load and clear are taken in the idle state and leave the core idle
// measure and render run multiply, sum, divider start and divide; a valid
//   render then checks, reads and accumulates; QI = clog2(max(SRC_W,SRC_H));
//   the two shared dividers produce one quotient bit per cycle
// render reads four source pixels through the single memory read port
// reset clears control state and the box; the source memory is not cleared
// a finished transaction sits in the output register while the next one runs
module homography_warp_bilinear_core #(
   parameter int SRC_W = hwb_pkg::HWB_SRC_W_DEF,
   parameter int SRC_H = hwb_pkg::HWB_SRC_H_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // req transaction
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // pos_x[9:0], pos_y[19:10], red_in[27:20], green_in[35:28], blue_in[43:36]
   input  logic [hwb_pkg::HWB_REQ_DW-1:0]   req_tdata,
   // cmd[1:0]
   input  logic [1:0]                       req_tuser,
   // rsp transaction
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // dest_x[8:0], dest_y[17:9], red_out[25:18], green_out[33:26],
   // blue_out[41:34], tex_index[59:42]
   output logic [hwb_pkg::HWB_RSP_DW-1:0]   rsp_tdata,
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [hwb_pkg::HWB_CSR_AW-1:0]   csr_paddr,
   input  logic [hwb_pkg::HWB_CSR_DW-1:0]   csr_pwdata,
   output logic [hwb_pkg::HWB_CSR_DW-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import hwb_pkg::*;

   localparam int QI  = $clog2((SRC_W > SRC_H) ? SRC_W : SRC_H);
   localparam int QW  = QI + HWB_CF;
   localparam int NW  = HWB_NUM_W;

   // coefficient registers
   logic signed [HWB_COEF_W-1:0] coef_ff [HWB_NREG];
   logic                         csr_wr;
   logic [2:0]                   csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[5:3];
   assign csr_prdata = {{(HWB_CSR_DW - HWB_COEF_W){coef_ff[csr_idx][HWB_COEF_W-1]}},
                        coef_ff[csr_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HWB_NREG; i++) begin
            coef_ff[i] <= (i == CSR_COEF_XX || i == CSR_COEF_YY) ? HWB_COEF_ONE : '0;
         end
      end else if (csr_wr) begin
         coef_ff[csr_idx] <= csr_pwdata[HWB_COEF_W-1:0];
      end
   end

   // pixel address, row major, wrapped to the memory
   function automatic logic [HWB_ADDR_W-1:0] pix_addr(input logic [QI:0] col,
                                                       input logic [QI:0] row);
      logic [HWB_CALC_W-1:0] full;
      full = HWB_CALC_W'(row) * HWB_CALC_W'(SRC_W) + HWB_CALC_W'(col);
      return full[HWB_ADDR_W-1:0];
   endfunction

   // input field split
   hwb_cmd_type   req_cmd;
   logic [9:0]    req_x, req_y;
   logic          req_acc;

   assign req_cmd = hwb_cmd_type'(req_tuser);
   assign req_x   = req_tdata[9:0];
   assign req_y   = req_tdata[19:10];
   assign req_acc = req_tvalid & req_tready;

   // control
   hwb_state_type state_ff, state_in;
   logic          div_start, rd_en, out_load;
   hwb_cmd_type   cmd_ff;
   logic [9:0]    x_ff, y_ff;
   logic [1:0]    rd_cnt_ff;
   logic          rsp_valid_ff;
   logic [HWB_RSP_DW-1:0] rsp_data_ff;

   // box state
   logic [HWB_BOX_W-1:0] box_min_x_ff, box_min_y_ff, box_max_x_ff, box_max_y_ff;
   logic                 box_empty_ff;

   // datapath registers
   logic signed [HWB_PROD_W-1:0] prod_ff [6];
   logic signed [NW-1:0]         w_ff, nu_ff, nv_ff;
   logic [HWB_ADDR_W-1:0]        addr_ff [4];
   logic [HWB_WGT_W-1:0]         wgt_ff [4];
   logic [HWB_ACC_W-1:0]         acc_ff [3];
   logic [8:0]                   dest_x_ff, dest_y_ff;
   logic [HWB_ADDR_W-1:0]        tex_ff;

   hwb_div_res_type div_u_res, div_v_res;
   logic            div_ok;

   // memory
   logic                  mem_wr;
   logic [HWB_ADDR_W-1:0] mem_wr_addr;
   logic [HWB_PIX_W-1:0]  mem_rd_data;

   assign mem_wr = req_acc && (req_cmd == CMD_LOAD) &&
                   ({2'b00, req_x} < 12'(SRC_W)) && ({2'b00, req_y} < 12'(SRC_H));
   assign mem_wr_addr = pix_addr((QI + 1)'(req_x), (QI + 1)'(req_y));

   hwb_pix_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (mem_wr_addr),
      .wr_data (req_tdata[43:20] == '0 ? '0 :
                {req_tdata[27:20], req_tdata[35:28], req_tdata[43:36]}),
      .rd_en   (rd_en),
      .rd_addr (addr_ff[rd_cnt_ff]),
      .rd_data (mem_rd_data)
   );

   hwb_div #(.QI(QI), .LIMIT(SRC_W)) u_div_u (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (nu_ff),
      .den   (w_ff),
      .res   (div_u_res)
   );

   hwb_div #(.QI(QI), .LIMIT(SRC_H)) u_div_v (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (nv_ff),
      .den   (w_ff),
      .res   (div_v_res)
   );

   assign div_ok = div_u_res.ok & div_v_res.ok;

   // grid point recentred on the source: trunc((2x - W) / 2)
   logic signed [12:0]          tx, ty;
   logic signed [HWB_UV_W-1:0]  gu, gv;

   assign tx = signed'({2'b00, x_ff, 1'b0}) - signed'(13'(SRC_W));
   assign ty = signed'({2'b00, y_ff, 1'b0}) - signed'(13'(SRC_H));
   assign gu = (tx[12] & tx[0]) ? HWB_UV_W'((tx + 13'sd1) >>> 1) : HWB_UV_W'(tx >>> 1);
   assign gv = (ty[12] & ty[0]) ? HWB_UV_W'((ty + 13'sd1) >>> 1) : HWB_UV_W'(ty >>> 1);

   // render checks on the quotients
   logic [QW-1:0]   qu, qv;
   logic [QI-1:0]   u0, v0;
   logic [15:0]     fx, fy;
   logic [QI:0]     u1, v1, ru, rv;
   logic            in_src;
   logic [11:0]     sx, sy;
   logic signed [14:0] dxn, dyn;
   logic signed [13:0] dx, dy;
   logic            in_dest;
   logic [16:0]     omx, omy;
   logic [33:0]     w00, w10, w01, w11;

   assign qu = div_u_res.quot[QW-1:0];
   assign qv = div_v_res.quot[QW-1:0];
   assign u0 = qu[QW-1:HWB_CF];
   assign v0 = qv[QW-1:HWB_CF];
   assign fx = qu[HWB_CF-1:0];
   assign fy = qv[HWB_CF-1:0];
   assign u1 = (QI + 1)'(u0) + (QI + 1)'(fx != '0);
   assign v1 = (QI + 1)'(v0) + (QI + 1)'(fy != '0);
   assign ru = (QI + 1)'(u0) + (QI + 1)'(fx[15]);
   assign rv = (QI + 1)'(v0) + (QI + 1)'(fy[15]);
   assign in_src = ((QI + 2)'(u1) < (QI + 2)'(SRC_W)) && ((QI + 2)'(v1) < (QI + 2)'(SRC_H));

   // destination: trunc((2x - S + W + 1) / 2), S the box sum
   assign sx  = box_empty_ff ? '0 : 12'(box_min_x_ff) + 12'(box_max_x_ff);
   assign sy  = box_empty_ff ? '0 : 12'(box_min_y_ff) + 12'(box_max_y_ff);
   assign dxn = signed'(15'({x_ff, 1'b0})) - signed'(15'(sx)) + signed'(15'(SRC_W + 1));
   assign dyn = signed'(15'({y_ff, 1'b0})) - signed'(15'(sy)) + signed'(15'(SRC_H + 1));
   assign dx  = (dxn[14] & dxn[0]) ? 14'((dxn + 15'sd1) >>> 1) : 14'(dxn >>> 1);
   assign dy  = (dyn[14] & dyn[0]) ? 14'((dyn + 15'sd1) >>> 1) : 14'(dyn >>> 1);
   assign in_dest = !dx[13] && !dy[13] &&
                    (14'(dx) < 14'(SRC_W)) && (14'(dy) < 14'(SRC_H));

   // bilinear weights, 16 fraction bits per axis
   assign omx = 17'h10000 - {1'b0, fx};
   assign omy = 17'h10000 - {1'b0, fy};
   assign w00 = {17'b0, omx} * {17'b0, omy};
   assign w10 = {18'b0, fx}  * {17'b0, omy};
   assign w01 = {17'b0, omx} * {18'b0, fy};
   assign w11 = {18'b0, fx}  * {18'b0, fy};

   // next state and control
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      rd_en     = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_cmd == CMD_MEASURE || req_cmd == CMD_RENDER)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_START;
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_u_res.done) begin
               if (div_ok && cmd_ff == CMD_RENDER) begin
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CHECK: begin
            state_in = (in_src && in_dest) ? ST_RD : ST_IDLE;
         end
         ST_RD: begin
            rd_en    = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = (rd_cnt_ff == 2'd3) ? ST_DONE : ST_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   // box tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_x_ff <= '1;
         box_min_y_ff <= '1;
         box_max_x_ff <= '0;
         box_max_y_ff <= '0;
         box_empty_ff <= 1'b1;
      end else if (req_acc && req_cmd == CMD_CLEAR) begin
         box_min_x_ff <= '1;
         box_min_y_ff <= '1;
         box_max_x_ff <= '0;
         box_max_y_ff <= '0;
         box_empty_ff <= 1'b1;
      end else if (state_ff == ST_DIV && div_u_res.done && div_ok &&
                   cmd_ff == CMD_MEASURE) begin
         if ({1'b0, x_ff} < box_min_x_ff) box_min_x_ff <= {1'b0, x_ff};
         if ({1'b0, y_ff} < box_min_y_ff) box_min_y_ff <= {1'b0, y_ff};
         if ({1'b0, x_ff} > box_max_x_ff) box_max_x_ff <= {1'b0, x_ff};
         if ({1'b0, y_ff} > box_max_y_ff) box_max_y_ff <= {1'b0, y_ff};
         box_empty_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff <= req_cmd;
         x_ff   <= req_x;
         y_ff   <= req_y;
      end
      if (state_ff == ST_MUL) begin
         prod_ff[0] <= coef_ff[CSR_COEF_XX] * gu;
         prod_ff[1] <= coef_ff[CSR_COEF_XY] * gv;
         prod_ff[2] <= coef_ff[CSR_COEF_YX] * gu;
         prod_ff[3] <= coef_ff[CSR_COEF_YY] * gv;
         prod_ff[4] <= coef_ff[CSR_COEF_WX] * gu;
         prod_ff[5] <= coef_ff[CSR_COEF_WY] * gv;
      end
      if (state_ff == ST_SUM) begin
         nu_ff <= NW'(prod_ff[0]) + NW'(prod_ff[1]) + NW'(coef_ff[CSR_COEF_XC]);
         nv_ff <= NW'(prod_ff[2]) + NW'(prod_ff[3]) + NW'(coef_ff[CSR_COEF_YC]);
         w_ff  <= NW'(prod_ff[4]) + NW'(prod_ff[5]) + HWB_W_ONE;
      end
      if (state_ff == ST_CHECK) begin
         addr_ff[0] <= pix_addr((QI + 1)'(u0), (QI + 1)'(v0));
         addr_ff[1] <= pix_addr(u1, (QI + 1)'(v0));
         addr_ff[2] <= pix_addr((QI + 1)'(u0), v1);
         addr_ff[3] <= pix_addr(u1, v1);
         wgt_ff[0]  <= w00[HWB_WGT_W-1:0];
         wgt_ff[1]  <= w10[HWB_WGT_W-1:0];
         wgt_ff[2]  <= w01[HWB_WGT_W-1:0];
         wgt_ff[3]  <= w11[HWB_WGT_W-1:0];
         dest_x_ff  <= dx[8:0];
         dest_y_ff  <= dy[8:0];
         tex_ff     <= pix_addr(ru, rv);
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= '0;
         end
      end
      if (state_ff == ST_ACC) begin
         // red in bits 23..16, green 15..8, blue 7..0
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= acc_ff[c] +
                         HWB_ACC_W'(mem_rd_data[16 - 8 * c +: 8]) *
                         HWB_ACC_W'(wgt_ff[rd_cnt_ff]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff <= '0;
      end else if (state_ff == ST_CHECK) begin
         rd_cnt_ff <= '0;
      end else if (state_ff == ST_ACC) begin
         rd_cnt_ff <= rd_cnt_ff + 2'd1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {4'b0, tex_ff,
                         acc_ff[2][HWB_ACC_W-1:32], acc_ff[1][HWB_ACC_W-1:32],
                         acc_ff[0][HWB_ACC_W-1:32], dest_y_ff, dest_x_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // both dividers run in lock step
   assert property (@(posedge clock) disable iff (reset)
      div_u_res.done == div_v_res.done)
      else $error("dividers out of step");

   // a finished render reaches the output register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) |=> rsp_tvalid)
      else $error("finished render not presented");

   // a filled box is never inverted
   assert property (@(posedge clock) disable iff (reset)
      !box_empty_ff |-> (box_min_x_ff <= box_max_x_ff && box_min_y_ff <= box_max_y_ff))
      else $error("box inverted");

   // no new transaction while a point is in flight
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("input taken while busy");
`endif

endmodule
